/* src/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// shared types, codes and defaults of the bounded double-ended queue
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int WORD_W           = 32;
  localparam int KIND_W           = 2;
  localparam int STATUS_W         = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load_pop;
  } bdq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_ok;
  } bdq_stat_t;

endpackage

/* src/bdq_ram.sv */
// ----------------------------------------------------------------------------
// bdq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/bdq_ctrl.sv */
// ----------------------------------------------------------------------------
// bdq_ctrl
// sequencer: take a word, wait for the ram read on a pop, hold the result
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bdq_pkg::bdq_stat_t stat,
  output bdq_pkg::bdq_cmd_t  cmd
);
  import bdq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_t;

  state_t state;

  assign cmd.accept   = in_valid && in_ready;
  assign cmd.load_pop = (state == ST_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            in_ready <= 1'b0;
            if (stat.pop_ok) begin
              state <= ST_READ;
            end else begin
              state     <= ST_OUT;
              out_valid <= 1'b1;
            end
          end
        end
        ST_READ: begin
          state     <= ST_OUT;
          out_valid <= 1'b1;
        end
        ST_OUT: begin
          if (out_ready) begin
            state     <= ST_IDLE;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open at once");

endmodule

/* src/bdq_dp.sv */
// ----------------------------------------------------------------------------
// bdq_dp
// datapath: front pointer, count, circular slot math, entry ram, result regs
// ----------------------------------------------------------------------------
module bdq_dp #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEFAULT,
  parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [bdq_pkg::KIND_W-1:0]        kind,
  input  logic signed [bdq_pkg::WORD_W-1:0] push_value,
  output logic signed [bdq_pkg::WORD_W-1:0] pop_value,
  output logic [bdq_pkg::STATUS_W-1:0]      status,
  output logic [CW-1:0]                     count,
  input  bdq_pkg::bdq_cmd_t                 cmd,
  output bdq_pkg::bdq_stat_t                stat
);
  import bdq_pkg::*;

  localparam int SW = CW + 1;

  logic [IW-1:0]     front;
  logic [IW-1:0]     front_next;
  logic [CW-1:0]     count_next;
  logic [IW-1:0]     front_dec;
  logic [IW-1:0]     front_inc;
  logic [SW-1:0]     back_sum;
  logic [SW-1:0]     last_sum;
  logic [IW-1:0]     back_slot;
  logic [IW-1:0]     last_slot;
  logic              full;
  logic              empty;
  logic              op_ok;
  logic              is_push;
  logic              we;
  logic [IW-1:0]     waddr;
  logic [IW-1:0]     raddr;
  logic [WORD_W-1:0] rdata;
  status_t           status_next;

  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);

  assign front_dec = (front == '0) ? IW'(CAPACITY - 1) : front - 1'b1;
  assign front_inc = (front == IW'(CAPACITY - 1)) ? '0 : front + 1'b1;

  // front + count stays below twice the capacity, one subtract wraps it
  assign back_sum  = SW'(front) + SW'(count);
  assign last_sum  = back_sum - 1'b1;
  assign back_slot = (back_sum >= SW'(CAPACITY)) ? IW'(back_sum - SW'(CAPACITY))
                                                 : IW'(back_sum);
  assign last_slot = (last_sum >= SW'(CAPACITY)) ? IW'(last_sum - SW'(CAPACITY))
                                                 : IW'(last_sum);

  always_comb begin
    front_next = front;
    count_next = count;
    waddr      = back_slot;
    raddr      = front;
    is_push    = 1'b0;
    op_ok      = 1'b0;
    unique case (kind_t'(kind))
      KIND_PUSH_FRONT: begin
        is_push    = 1'b1;
        op_ok      = !full;
        waddr      = front_dec;
        front_next = front_dec;
        count_next = count + 1'b1;
      end
      KIND_PUSH_BACK: begin
        is_push    = 1'b1;
        op_ok      = !full;
        waddr      = back_slot;
        count_next = count + 1'b1;
      end
      KIND_POP_FRONT: begin
        op_ok      = !empty;
        raddr      = front;
        front_next = front_inc;
        count_next = count - 1'b1;
      end
      KIND_POP_BACK: begin
        op_ok      = !empty;
        raddr      = last_slot;
        count_next = count - 1'b1;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
    if (op_ok) begin
      status_next = STATUS_DONE;
    end else if (is_push) begin
      status_next = STATUS_FULL;
    end else begin
      status_next = STATUS_EMPTY;
    end
  end

  assign we          = cmd.accept && is_push && op_ok;
  assign stat.pop_ok = !is_push && op_ok;

  bdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (push_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.accept && op_ok) begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status    <= status_next;
      pop_value <= '0;
    end else if (cmd.load_pop) begin
      pop_value <= signed'(rdata);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count beyond capacity");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && !op_ok |=> $stable(count) && $stable(front))
    else $error("rejected word changed the queue");

  a_pop_read: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && stat.pop_ok |=> cmd.load_pop)
    else $error("pop not followed by ram read");

endmodule

/* src/bounded_double_ended_queue_top.sv */
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top
// bounded double-ended queue of signed 32-bit words
// ----------------------------------------------------------------------------
// input channel in_valid/in_ready carries one operation word: kind (push front,
// push back, pop front, pop back) and push_value. output channel
// out_valid/out_ready returns one result word per operation: pop_value, status
// (done, full, empty) and count after the operation.
// one operation at a time: a push or a rejected word shows its result in the
// cycle after acceptance; a pop first waits in state ST_READ for the registered
// entry ram read, then loads pop_value. in_ready rises again the cycle after
// the result is taken.
// while the receiver stalls the result is held and no new word is taken.
// reset empties the queue (front pointer and count to zero); the entry ram is
// not cleared, a pop only ever reads entries written by a push.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_top #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEFAULT,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bdq_pkg::KIND_W-1:0]        kind,
  input  logic signed [bdq_pkg::WORD_W-1:0] push_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bdq_pkg::WORD_W-1:0] pop_value,
  output logic [bdq_pkg::STATUS_W-1:0]      status,
  output logic [CW-1:0]                     count
);
  import bdq_pkg::*;

  bdq_cmd_t  cmd;
  bdq_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdq_dp #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .kind       (kind),
    .push_value (push_value),
    .pop_value  (pop_value),
    .status     (status),
    .count      (count),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// checks bounded_double_ended_queue_top against a cycle-free deque predictor
// ----------------------------------------------------------------------------
// every accepted operation word is run through a circular-store predictor and
// its expected result is queued. every accepted result word is compared field
// by field with the oldest expected one. a directed run covers empty pops,
// extreme values, filling to full with index wrap and full pushes. it is
// followed by random bursts whose phases lean toward pushes, toward pops or
// neither, so that the count sweeps the whole range. the receiver stalls on its
// own changing pattern.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int CAP          = CAPACITY_DEFAULT;
  localparam int CNT_W        = $clog2(CAP + 1);
  localparam int RANDOM_ITEMS = 480;
  localparam int DRAIN_EVERY  = 120;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    status_t                  status;
    logic [CNT_W-1:0]         count;
  } deque_result_t;

  class deque_scoreboard;
    logic signed [WORD_W-1:0] slots [CAP];
    int                       head;
    int                       held;
    deque_result_t            awaited [$];
    int                       mismatches;

    function new();
      head       = 0;
      held       = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_word(kind_t op, logic signed [WORD_W-1:0] value);
      deque_result_t r;
      r.pop_value = '0;
      r.status    = STATUS_DONE;
      case (op)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (held >= CAP) begin
            r.status = STATUS_FULL;
          end else if (op == KIND_PUSH_FRONT) begin
            head        = (head + CAP - 1) % CAP;
            slots[head] = value;
            held++;
          end else begin
            slots[(head + held) % CAP] = value;
            held++;
          end
        end
        default: begin
          if (held == 0) begin
            r.status = STATUS_EMPTY;
          end else if (op == KIND_POP_FRONT) begin
            r.pop_value = slots[head];
            head        = (head + 1) % CAP;
            held--;
          end else begin
            held--;
            r.pop_value = slots[(head + held) % CAP];
          end
        end
      endcase
      r.count = CNT_W'(held);
      awaited.push_back(r);
    endfunction

    function void check_word(logic signed [WORD_W-1:0] got_value,
                             logic [STATUS_W-1:0] got_status,
                             logic [CNT_W-1:0] got_count);
      deque_result_t r;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: pop_value %h status %0d count %0d",
                   got_value, got_status, got_count);
        return;
      end
      r = awaited.pop_front();
      if (got_value !== r.pop_value || got_status !== r.status || got_count !== r.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected pop_value %h status %0d count %0d, got %h %0d %0d",
                   r.pop_value, r.status, r.count, got_value, got_status, got_count);
      end
    endfunction
  endclass

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     in_valid   = 1'b0;
  logic                     out_ready  = 1'b0;
  logic [KIND_W-1:0]        kind       = '0;
  logic signed [WORD_W-1:0] push_value = '0;
  logic                     in_ready;
  logic                     out_valid;
  logic signed [WORD_W-1:0] pop_value;
  logic [STATUS_W-1:0]      status;
  logic [CNT_W-1:0]         count;

  int unsigned      cycles     = 0;
  int unsigned      ready_mode = 0;
  deque_scoreboard  sb         = new();

  bounded_double_ended_queue_top #(.CAPACITY(CAP)) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pop_value  (pop_value),
    .status     (status),
    .count      (count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bounded_double_ended_queue_top verification failed");
      $finish;
    end
  end

  // receiver: checks each taken result word; its stall pattern is picked at random from four modes
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word(pop_value, status, count);
    if (cycles % 64 == 0)
      ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((cycles % 8) == 7);
    endcase
  end

  task automatic send_word(kind_t op, logic signed [WORD_W-1:0] value);
    in_valid   <= 1'b1;
    kind       <= op;
    push_value <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_word(kind_t'(kind), push_value);
  endtask

  task automatic idle(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int                       sent;
    int                       phase_left;
    int                       bias;
    int                       burst;
    int                       roll;
    int                       next_drain;
    int                       gap;
    bit                       push_op;
    kind_t                    op;
    logic signed [WORD_W-1:0] value;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pops, extremes, then fill past the front wrap and push when full
    send_word(KIND_POP_FRONT, 32'sh12345678);
    send_word(KIND_POP_BACK, -32'sd1);
    send_word(KIND_PUSH_FRONT, 32'sh80000000);
    send_word(KIND_PUSH_BACK, 32'sh7fffffff);
    send_word(KIND_POP_FRONT, '0);
    send_word(KIND_POP_BACK, '0);
    for (int i = 0; i < CAP; i++) begin
      case (i % 4)
        0: send_word(KIND_PUSH_FRONT, 32'shaaaaaaaa);
        1: send_word(KIND_PUSH_BACK, 32'sh55555555);
        2: send_word(KIND_PUSH_FRONT, -32'sd1);
        default: send_word(KIND_PUSH_BACK, '0);
      endcase
    end
    send_word(KIND_PUSH_FRONT, 32'sh0badf00d);
    send_word(KIND_PUSH_BACK, 32'sh7fffffff);
    drain();

    sent       = 0;
    phase_left = 0;
    bias       = 0;
    next_drain = DRAIN_EVERY;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left <= 0) begin
        phase_left = $urandom_range(10, 40);
        bias       = $urandom_range(0, 3);
      end
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        case (bias)
          0: push_op = (roll < 80);
          1: push_op = (roll < 20);
          default: push_op = (roll < 50);
        endcase
        if (push_op)
          op = ($urandom_range(0, 1) == 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        else
          op = ($urandom_range(0, 1) == 1) ? KIND_POP_BACK : KIND_POP_FRONT;
        case ($urandom_range(0, 7))
          0: value = 32'sh7fffffff;
          1: value = 32'sh80000000;
          2: value = '0;
          3: value = -32'sd1;
          default: value = $urandom;
        endcase
        send_word(op, value);
        sent++;
        phase_left--;
      end
      if (sent >= next_drain) begin
        drain();
        next_drain += DRAIN_EVERY;
      end else begin
        gap = $urandom_range(0, 6);
        if (gap != 0)
          idle(gap);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("bounded_double_ended_queue_top verification clean");
    end else begin
      $display("bounded_double_ended_queue_top verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/bdq_pkg.sv
src/bdq_ram.sv
src/bdq_ctrl.sv
src/bdq_dp.sv
src/bounded_double_ended_queue_top.sv
tb/testbench.sv
